FILE: design/actr_pkg.sv
`timescale 1ns / 1ps

package actr_pkg;

  localparam int unsigned BlockBits  = 128;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned HalfBits   = 64;
  localparam int unsigned KsQueueDepth = 2;

  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_INIT_VEC = 2'd2,
    REG_UNUSED   = 2'd3
  } cfg_reg_e;

  // one keystream block and the counter value it was made from
  typedef struct packed {
    logic [BlockBits-1:0] block;
    logic [BlockBits-1:0] ctr;
  } ks_entry_t;

  // drop all prefetched keystream and restart generation at ctr
  typedef struct packed {
    logic                 flush;
    logic [BlockBits-1:0] ctr;
  } restart_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] blk_byte(logic [BlockBits-1:0] b, logic [3:0] i);
    logic [BlockBits-1:0] sh;
    sh = b << {i, 3'b000};
    return sh[BlockBits-1 -: ByteBits];
  endfunction

endpackage

FILE: design/actr_keygen.sv
`timescale 1ns / 1ps

module actr_keygen (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [actr_pkg::BlockBits-1:0] key_i,
  input  actr_pkg::restart_t            restart_i,
  output logic                          ks_valid_o,
  input  logic                          ks_ready_i,
  output actr_pkg::ks_entry_t           ks_entry_o
);

  localparam int unsigned BB = actr_pkg::BlockBits;

  function automatic logic [7:0] xtime(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  logic          busy_q, busy_d, done_q, done_d;
  logic [3:0]    round_q, round_d;
  logic [BB-1:0] state_q, state_d, rkey_q, rkey_d;
  logic [BB-1:0] ctr_q, ctr_d, gen_ctr_q, gen_ctr_d;
  logic [BB-1:0] rk_next, sr, mixed, round_out;
  logic [31:0]   w3, tw;

  // one key schedule step, round key computed on the fly
  always_comb begin
    w3 = rkey_q[31:0];
    tw = {actr_pkg::SBOX[w3[23:16]] ^ rcon(round_q), actr_pkg::SBOX[w3[15:8]],
          actr_pkg::SBOX[w3[7:0]], actr_pkg::SBOX[w3[31:24]]};
    rk_next[127:96] = rkey_q[127:96] ^ tw;
    rk_next[95:64]  = rkey_q[95:64] ^ rk_next[127:96];
    rk_next[63:32]  = rkey_q[63:32] ^ rk_next[95:64];
    rk_next[31:0]   = rkey_q[31:0] ^ rk_next[63:32];
  end

  // subbytes and shiftrows
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        sr[BB-1-8*(k+4*c) -: 8] =
          actr_pkg::SBOX[actr_pkg::blk_byte(state_q, 4'((k + 4*((c + k) % 4))))];
      end
    end
  end

  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = sr[BB-1-32*c -: 8];
      a1 = sr[BB-9-32*c -: 8];
      a2 = sr[BB-17-32*c -: 8];
      a3 = sr[BB-25-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mixed[BB-1-32*c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
      mixed[BB-9-32*c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      mixed[BB-17-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      mixed[BB-25-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
  end

  assign round_out = ((round_q == 4'd10) ? sr : mixed) ^ rk_next;

  always_comb begin
    busy_d    = busy_q;
    done_d    = done_q;
    round_d   = round_q;
    state_d   = state_q;
    rkey_d    = rkey_q;
    ctr_d     = ctr_q;
    gen_ctr_d = gen_ctr_q;
    if (restart_i.flush) begin
      busy_d    = 1'b0;
      done_d    = 1'b0;
      gen_ctr_d = restart_i.ctr;
    end else if (busy_q) begin
      state_d = round_out;
      rkey_d  = rk_next;
      round_d = round_q + 4'd1;
      if (round_q == 4'd10) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (done_q) begin
      if (ks_ready_i) done_d = 1'b0;
    end else begin
      busy_d    = 1'b1;
      round_d   = 4'd1;
      state_d   = gen_ctr_q ^ key_i;
      rkey_d    = key_i;
      ctr_d     = gen_ctr_q;
      gen_ctr_d = gen_ctr_q + BB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      round_q   <= 4'd0;
      gen_ctr_q <= BB'(1);
    end else begin
      busy_q    <= busy_d;
      done_q    <= done_d;
      round_q   <= round_d;
      gen_ctr_q <= gen_ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rkey_q  <= rkey_d;
    ctr_q   <= ctr_d;
  end

  assign ks_valid_o       = done_q;
  assign ks_entry_o.block = state_q;
  assign ks_entry_o.ctr   = ctr_q;

endmodule

FILE: design/actr_ks_queue.sv
`timescale 1ns / 1ps

module actr_ks_queue #(
  parameter int unsigned Depth = actr_pkg::KsQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                flush_i,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  actr_pkg::ks_entry_t push_entry_i,
  output logic                head_valid_o,
  input  logic                pop_i,
  output actr_pkg::ks_entry_t head_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  actr_pkg::ks_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_entry_o = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (flush_i) begin
      wr_d  = '0;
      rd_d  = '0;
      cnt_d = '0;
    end else begin
      if (push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      cnt_d = cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !flush_i) mem_q[wr_q] <= push_entry_i;
  end

endmodule

FILE: design/actr_front.sv
`timescale 1ns / 1ps

module actr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [actr_pkg::HalfBits-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,
  output logic                           m_axis_tlast,
  output logic [actr_pkg::BlockBits-1:0] key_o,
  output actr_pkg::restart_t             restart_o,
  input  logic                           head_valid_i,
  input  actr_pkg::ks_entry_t            head_entry_i,
  output logic                           pop_o
);

  localparam int unsigned BB = actr_pkg::BlockBits;
  localparam int unsigned HB = actr_pkg::HalfBits;

  logic [HB-1:0] keyh_q, keyl_q, iv_q;
  logic          cur_v_q, msg_q, out_v_q;
  logic [3:0]    pos_q;
  logic [BB-1:0] cur_ks_q, cur_ctr_q;
  logic [7:0]    out_byte_q, ks_byte;
  logic          out_last_q, accept, cfg_wr;

  assign cfg_ready_o   = 1'b1;
  assign cfg_wr        = cfg_valid_i;
  assign s_axis_tready = (!out_v_q || m_axis_tready) && (cur_v_q || head_valid_i);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop_o         = accept && !cur_v_q;
  assign ks_byte       = cur_v_q ? actr_pkg::blk_byte(cur_ks_q, pos_q)
                                 : actr_pkg::blk_byte(head_entry_i.block, 4'd0);
  assign key_o         = {keyh_q, keyl_q};

  // prefetched keystream is dropped when a message closes, on a key write, or on an IV write between messages
  always_comb begin
    restart_o.flush = 1'b0;
    restart_o.ctr   = {iv_q, HB'(1)};
    if (cfg_wr) begin
      unique case (actr_pkg::cfg_reg_e'(cfg_index_i))
        actr_pkg::REG_KEY_HIGH, actr_pkg::REG_KEY_LOW: begin
          restart_o.flush = 1'b1;
          if (msg_q) restart_o.ctr = cur_ctr_q + BB'(1);
        end
        actr_pkg::REG_INIT_VEC: begin
          restart_o.flush = !msg_q;
          restart_o.ctr   = {cfg_data_i, HB'(1)};
        end
        default: ;
      endcase
    end else if (accept && s_axis_tlast) begin
      restart_o.flush = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyh_q  <= '0;
      keyl_q  <= '0;
      iv_q    <= '0;
      cur_v_q <= 1'b0;
      msg_q   <= 1'b0;
      out_v_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (actr_pkg::cfg_reg_e'(cfg_index_i))
          actr_pkg::REG_KEY_HIGH: keyh_q <= cfg_data_i;
          actr_pkg::REG_KEY_LOW:  keyl_q <= cfg_data_i;
          actr_pkg::REG_INIT_VEC: iv_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        out_v_q <= 1'b1;
        msg_q   <= !s_axis_tlast;
        if (!cur_v_q) begin
          pos_q   <= 4'd1;
          cur_v_q <= !s_axis_tlast;
        end else begin
          pos_q   <= pos_q + 4'd1;
          cur_v_q <= (pos_q != 4'd15) && !s_axis_tlast;
        end
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q <= s_axis_tdata ^ ks_byte;
      out_last_q <= s_axis_tlast;
    end
    if (pop_o) begin
      cur_ks_q  <= head_entry_i.block;
      cur_ctr_q <= head_entry_i.ctr;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: design/aes128_ctr_stream_cipher_unit.sv
`timescale 1ns / 1ps

// AES-128 counter-mode byte cipher: each byte transferred in leaves XORed with
// the next keystream byte, one byte per cycle within a message while the output
// is not stalled. Keystream blocks come from an iterative round unit (one AES
// round per cycle) and are prefetched into a two-entry queue, so the 16 bytes
// of a block cover the next block's generation. The first byte of a message,
// and the first byte after a key write, waits while counter block IV||1 (or
// the next counter under the new key) is encrypted. Registers: 0 key high, 1
// key low, 2 IV; write them only with no byte outstanding.
module aes128_ctr_stream_cipher_unit #(
  parameter int unsigned KsQueueDepth = actr_pkg::KsQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast
);

  logic [actr_pkg::BlockBits-1:0] key;
  actr_pkg::restart_t  restart;
  actr_pkg::ks_entry_t gen_entry, head_entry;
  logic gen_valid, gen_ready, head_valid, pop;

  actr_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .key_o        (key),
    .restart_o    (restart),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop)
  );

  actr_ks_queue #(.Depth(KsQueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .flush_i      (restart.flush),
    .push_valid_i (gen_valid),
    .push_ready_o (gen_ready),
    .push_entry_i (gen_entry),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_entry_o (head_entry)
  );

  actr_keygen u_keygen (
    .clk_i, .rst_ni,
    .key_i      (key),
    .restart_i  (restart),
    .ks_valid_o (gen_valid),
    .ks_ready_i (gen_ready),
    .ks_entry_o (gen_entry)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  class byte_scoreboard;
    logic [7:0] exp_byte_q[$];
    logic       exp_last_q[$];
    int         mismatches;
    int         checked;

    function void note_input(logic [7:0] b, logic l);
      exp_byte_q.push_back(b);
      exp_last_q.push_back(l);
    endfunction

    function void check_output(logic [7:0] b, logic l);
      logic [7:0] eb;
      logic       el;
      if (exp_byte_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output byte %h last %b", b, l);
        return;
      end
      eb = exp_byte_q.pop_front();
      el = exp_last_q.pop_front();
      checked++;
      if (eb !== b || el !== l) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h/%b got %h/%b", eb, el, b, l);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [7:0]  m_axis_tdata;        // [7:0] out_byte
  logic        m_axis_tlast;

  aes128_ctr_stream_cipher_unit u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  byte_scoreboard sb = new();

  // predictor state
  logic [63:0]  key_hi_q, key_lo_q, iv_q;
  logic [127:0] ctr_q;
  logic [7:0]   ks_q[16];
  int unsigned  ks_pos;
  bit           msg_open;
  logic [7:0]   rk[176];

  int  cycles;
  int  sent;
  int  msgs;
  bit  hold_off;
  bit  quiet_rx;

  function automatic logic [7:0] xt(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void expand_round_keys();
    logic [7:0] t[4];
    logic [7:0] f;
    for (int k = 0; k < 8; k++) begin
      rk[k]     = key_hi_q[63-8*k -: 8];
      rk[k + 8] = key_lo_q[63-8*k -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int k = 0; k < 4; k++) t[k] = rk[i - 4 + k];
      if ((i % 16) == 0) begin
        f = t[0];
        t[0] = actr_pkg::SBOX[t[1]] ^ (8'h01 << ((i / 16) - 1)) ^
               (((i / 16) == 9) ? 8'h1b : 8'h00) ^ (((i / 16) == 10) ? 8'h36 : 8'h00);
        t[1] = actr_pkg::SBOX[t[2]];
        t[2] = actr_pkg::SBOX[t[3]];
        t[3] = actr_pkg::SBOX[f];
      end
      for (int k = 0; k < 4; k++) rk[i + k] = rk[i - 16 + k] ^ t[k];
    end
  endfunction

  function automatic void encrypt_counter();
    logic [7:0] s[16], t[16];
    logic [7:0] a0, a1, a2, a3, al;
    for (int k = 0; k < 16; k++) s[k] = ctr_q[127-8*k -: 8] ^ rk[k];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++) t[k + 4*c] = actr_pkg::SBOX[s[k + 4*((c + k) % 4)]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
        end
      end
      for (int k = 0; k < 16; k++) s[k] = t[k] ^ rk[16*r + k];
    end
    for (int k = 0; k < 16; k++) ks_q[k] = s[k];
  endfunction

  function automatic void predict_cipher_byte(logic [7:0] d, logic l);
    if (!msg_open) begin
      ctr_q = {iv_q, 64'd0};
      ks_pos = 16;
      msg_open = 1;
    end
    if (ks_pos >= 16) begin
      ctr_q = ctr_q + 128'd1;
      encrypt_counter();
      ks_pos = 0;
    end
    sb.note_input(d ^ ks_q[ks_pos], l);
    ks_pos++;
    if (l) msg_open = 0;
  endfunction

  task automatic write_reg(actr_pkg::cfg_reg_e idx, logic [63:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    case (idx)
      actr_pkg::REG_KEY_HIGH: begin key_hi_q = val; expand_round_keys(); end
      actr_pkg::REG_KEY_LOW:  begin key_lo_q = val; expand_round_keys(); end
      actr_pkg::REG_INIT_VEC: iv_q = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] d, logic l);
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_cipher_byte(d, l);
    sent++;
    if (l) msgs++;
  endtask

  task automatic idle_sender(int n);
    s_axis_tvalid <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  // random message: mostly short, a few long ones to cross many blocks
  task automatic send_message(int len, int max_gap);
    int burst;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
      if (--burst == 0) begin
        burst = $urandom_range(1, 20);
        if (max_gap > 0 && $urandom_range(0, 2) == 0) idle_sender($urandom_range(1, max_gap));
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.exp_byte_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic new_setting(logic [63:0] kh, logic [63:0] kl, logic [63:0] iv);
    drain();
    write_reg(actr_pkg::REG_KEY_HIGH, kh);
    write_reg(actr_pkg::REG_KEY_LOW, kl);
    write_reg(actr_pkg::REG_INIT_VEC, iv);
  endtask

  // receiver: random stall pattern, quiet stretches, and one long hold-off
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata, m_axis_tlast);
    if (hold_off) m_axis_tready <= 0;
    else if (quiet_rx) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    hold_off = 1;
    repeat (200) @(posedge clk_i);
    hold_off = 0;
  end

  initial begin
    logic [63:0] vals[4];
    key_hi_q = 0; key_lo_q = 0; iv_q = 0;
    ctr_q = 0; ks_pos = 16; msg_open = 0;
    expand_round_keys();
    quiet_rx = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    repeat (5) @(posedge clk_i);

    // reset key and iv, extremes of the data byte; fills up during hold-off
    send_byte(8'h00, 0);
    send_byte(8'hff, 0);
    send_byte(8'h55, 0);
    send_byte(8'haa, 1);
    send_message(40, 0);
    send_byte(8'h3c, 1);

    // all-ones key and iv, short message; the lower half starts at 1, so it
    // does not wrap within a message this short
    new_setting('1, '1, '1);
    send_message(20, 0);
    new_setting(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'hf0f1f2f3f4f5f6f7);
    send_message(33, 3);

    // unused register index must be ignored
    drain();
    write_reg(actr_pkg::REG_UNUSED, {$urandom(), $urandom()});

    // key change in the middle of a message
    send_message(5, 0);
    send_byte(8'h11, 0);
    send_byte(8'h22, 0);
    drain();
    write_reg(actr_pkg::REG_KEY_LOW, 64'h0123456789abcdef);
    write_reg(actr_pkg::REG_INIT_VEC, 64'h8000000000000000);
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(0, 255)), i == 19);

    vals[0] = 0; vals[1] = '1; vals[2] = 64'h8000000000000001; vals[3] = 64'h7fffffffffffffff;
    while (sent < 1300) begin
      if ($urandom_range(0, 9) == 0) begin
        quiet_rx = $urandom_range(0, 1);
        if ($urandom_range(0, 1))
          new_setting(vals[$urandom_range(0, 3)], vals[$urandom_range(0, 3)],
                      vals[$urandom_range(0, 3)]);
        else
          new_setting({$urandom(), $urandom()}, {$urandom(), $urandom()},
                      {$urandom(), $urandom()});
      end
      if ($urandom_range(0, 15) == 0) send_message($urandom_range(40, 100), 4);
      else send_message($urandom_range(1, 24), 6);
      if ($urandom_range(0, 1)) idle_sender($urandom_range(1, 15));
    end

    quiet_rx = 0;
    drain();
    $display("sent %0d bytes in %0d messages, %0d checked", sent, msgs, sb.checked);
    $display("covered reset key, extreme and random keys and ivs, mid-message key writes");
    if (sb.mismatches == 0 && sb.exp_byte_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("mismatches: %0d", sb.mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/actr_pkg.sv
design/actr_keygen.sv
design/actr_ks_queue.sv
design/actr_front.sv
design/aes128_ctr_stream_cipher_unit.sv
verif/tb_top.sv
